@@ src/hse_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hse_pkg
// Shared types, constants and lookup functions for the Hall speed and
// angle estimator.
// ----------------------------------------------------------------------------
package hse_pkg;

    localparam int WINDOW_DEF  = 6;
    localparam int PERIOD_W    = 32;
    localparam int NUM_W       = 32;
    localparam int OMEGA_W     = 32;
    localparam int SECTOR_W    = 3;
    localparam int ANGLE_W     = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 56;

    // hall codes v<<2 | w<<1 | u
    localparam logic [2:0] HALL_S0 = 3'b011;
    localparam logic [2:0] HALL_S1 = 3'b001;
    localparam logic [2:0] HALL_S2 = 3'b101;
    localparam logic [2:0] HALL_S3 = 3'b100;
    localparam logic [2:0] HALL_S4 = 3'b110;
    localparam logic [2:0] HALL_S5 = 3'b010;

    localparam logic [SECTOR_W-1:0] SECTOR_NONE = 3'd7;

    typedef struct packed {
        logic load;
        logic update;
        logic mul;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic sum_zero;
    } t_dp_stat;

    function automatic logic [SECTOR_W-1:0] sector_of_code(input logic [2:0] code);
        logic [SECTOR_W-1:0] sec;
        unique case (code)
            HALL_S0: sec = 3'd0;
            HALL_S1: sec = 3'd1;
            HALL_S2: sec = 3'd2;
            HALL_S3: sec = 3'd3;
            HALL_S4: sec = 3'd4;
            HALL_S5: sec = 3'd5;
            default: sec = SECTOR_NONE;
        endcase
        return sec;
    endfunction

    function automatic logic [ANGLE_W-1:0] angle_of_sector(input logic [SECTOR_W-1:0] sec);
        logic [ANGLE_W-1:0] ang;
        unique case (sec)
            3'd0:    ang = 16'd0;
            3'd1:    ang = 16'd10923;
            3'd2:    ang = 16'd21845;
            3'd3:    ang = 16'd32768;
            3'd4:    ang = 16'd43691;
            3'd5:    ang = 16'd54613;
            default: ang = 16'd0;
        endcase
        return ang;
    endfunction

endpackage
`default_nettype wire

@@ src/hall_speed_angle_estimator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hall_speed_angle_estimator
// Per Hall edge: windowed average speed in Q24.8 rad/s and sector angle.
//
//   channel  dir  signals                              word
//   s        in   i_s_tvalid o_s_tready i_s_tdata      one Hall edge
//   m        out  o_m_tvalid i_m_tready o_m_tdata      one speed/angle result
//   cfg      in   i_cfg_valid o_cfg_ready i_cfg_data   speed numerator
//
// One edge at a time: accept, window update, multiply, then a restoring
// divider with one quotient bit per cycle over 32+clog2(WINDOW+1) bits,
// skipped when the window sum is zero. The next edge is taken in the cycle
// after the result loads. Synchronous active-low reset clears sum, fill
// count, slot, held sector and numerator. A result waiting on a stalled m
// channel does not block the next accept; only the final handoff waits.
// ----------------------------------------------------------------------------
module hall_speed_angle_estimator #(
    parameter int WINDOW = hse_pkg::WINDOW_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // period_count[31:0], hall_u[32], hall_v[33], hall_w[34], zero pad
    input  wire logic [hse_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // omega[31:0], speed_saturated[32], sector[35:33], rotor_angle[51:36],
    // hall_valid[52], zero pad
    output logic      [hse_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [hse_pkg::NUM_W-1:0]        i_cfg_data
);
    import hse_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    hse_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    hse_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_m_tdata   (o_m_tdata)
    );

    // one edge at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while busy");

    a_sat_omega: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[32]) |-> (o_m_tdata[31:0] == 32'hFFFF_FFFF))
        else $error("saturated speed not at maximum");

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[35:33] < 3'd6))
        else $error("sector out of range");

    a_angle_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[51:36] == angle_of_sector(o_m_tdata[35:33])))
        else $error("angle does not match sector");

endmodule
`default_nettype wire

@@ src/hse_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hse_ctrl
// Sequencer: takes an edge, steps the window update, multiply and serial
// divide (skipped on a zero window sum), then hands the result to the output register.
// ----------------------------------------------------------------------------
module hse_ctrl #(
    parameter int WINDOW = hse_pkg::WINDOW_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    input  wire hse_pkg::t_dp_stat i_stat,
    output hse_pkg::t_dp_cmd      o_cmd
);
    import hse_pkg::*;

    localparam int FW = $clog2(WINDOW + 1);
    localparam int DW = NUM_W + FW;
    localparam int CW = $clog2(DW + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_m_valid, n_m_valid;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_m_valid = r_m_valid;
        o_cmd     = '0;
        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_UPD;
                end
            end
            ST_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = CW'(DW);
                n_state   = i_stat.sum_zero ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_valid;

endmodule
`default_nettype wire

@@ src/hse_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hse_dp
// Datapath: period ring and running sum, sector lookup, multiplier,
// restoring divider and output register.
// ----------------------------------------------------------------------------
module hse_dp #(
    parameter int WINDOW = hse_pkg::WINDOW_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire hse_pkg::t_dp_cmd                 i_cmd,
    output hse_pkg::t_dp_stat                     o_stat,
    input  wire logic [hse_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  wire logic                             i_cfg_valid,
    input  wire logic [hse_pkg::NUM_W-1:0]        i_cfg_data,
    output logic      [hse_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import hse_pkg::*;

    localparam int FW  = $clog2(WINDOW + 1);
    localparam int SW  = PERIOD_W + FW;
    localparam int DW  = NUM_W + FW;
    localparam int SLW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [SLW-1:0] SLOT_LAST = SLW'(WINDOW - 1);
    localparam logic [FW-1:0]  FILL_FULL = FW'(WINDOW);

    logic [PERIOD_W-1:0] r_ring [WINDOW];
    logic [SW-1:0]       r_sum;
    logic [SLW-1:0]      r_slot;
    logic [FW-1:0]       r_fill;
    logic [SECTOR_W-1:0] r_held;
    logic [NUM_W-1:0]    r_num;
    logic [PERIOD_W-1:0] r_period;
    logic [2:0]          r_code;
    logic                r_hvalid;
    logic [DW-1:0]       r_dvd;
    logic [SW-1:0]       r_rem;
    logic [OUT_TDATA_W-1:0] r_out;

    logic [PERIOD_W-1:0] w_old;
    logic [SW-1:0]       w_sum_next;
    logic [SECTOR_W-1:0] w_sec;
    logic [DW-1:0]       w_prod;
    logic [SW:0]         w_trial;
    logic [SW:0]         w_diff;
    logic                w_qbit;
    logic                w_sat;
    logic [OMEGA_W-1:0]  w_omega;

    // until the window is full the dropped period counts as zero; the ring itself has no reset
    assign w_old      = (r_fill == FILL_FULL) ? r_ring[r_slot] : '0;
    assign w_sum_next = r_sum - SW'(w_old) + SW'(r_period);
    assign w_sec      = sector_of_code(r_code);
    assign w_prod     = DW'(r_num) * DW'(r_fill);
    assign w_trial    = {r_rem, r_dvd[DW-1]};
    assign w_diff     = w_trial - {1'b0, r_sum};
    assign w_qbit     = (w_trial >= {1'b0, r_sum});
    assign w_sat      = (r_sum == '0) || (|r_dvd[DW-1:OMEGA_W]);
    assign w_omega    = w_sat ? '1 : r_dvd[OMEGA_W-1:0];

    assign o_stat.sum_zero = (r_sum == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_slot <= '0;
            r_fill <= '0;
            r_held <= '0;
            r_num  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_num <= i_cfg_data;
            end
            if (i_cmd.update) begin
                r_sum  <= w_sum_next;
                r_slot <= (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
                if (r_fill != FILL_FULL) begin
                    r_fill <= r_fill + 1'b1;
                end
                if (w_sec != SECTOR_NONE) begin
                    r_held <= w_sec;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_period <= i_s_tdata[PERIOD_W-1:0];
            r_code   <= {i_s_tdata[PERIOD_W+1], i_s_tdata[PERIOD_W+2], i_s_tdata[PERIOD_W]};
        end
        if (i_cmd.update) begin
            r_ring[r_slot] <= r_period;
            r_hvalid       <= (w_sec != SECTOR_NONE);
        end
        if (i_cmd.mul) begin
            r_dvd <= w_prod;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[DW-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[SW-1:0] : w_trial[SW-1:0];
        end
        if (i_cmd.out_load) begin
            r_out <= {3'b000, r_hvalid, angle_of_sector(r_held), r_held, w_sat, w_omega};
        end
    end

    assign o_m_tdata = r_out;

endmodule
`default_nettype wire

@@ test/hall_speed_angle_estimator_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hall_speed_angle_estimator_test
// Self-checking bench for the Hall speed and angle estimator. Hall edge words
// go in on the s stream and the speed numerator on the cfg channel. A
// scoreboard keeps its own period window, fill count and held sector. It
// works out the speed, saturation, sector, angle and code check for every
// accepted edge and compares each result word field by field in order.
// Directed edges cover saturation, illegal codes, every legal code and
// field extremes. Random runs of rotor sequences with noise follow at
// several numerator settings, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module hall_speed_angle_estimator_test;
    import hse_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [2:0] HALL_ALL_LOW  = 3'b000;
    localparam logic [2:0] HALL_ALL_HIGH = 3'b111;
    localparam logic [17:0] ROTATION = {HALL_S5, HALL_S4, HALL_S3, HALL_S2, HALL_S1, HALL_S0};

    typedef struct packed {
        logic [4:0]          pad;
        logic                hall_w;
        logic                hall_v;
        logic                hall_u;
        logic [PERIOD_W-1:0] period_count;
    } t_hall_edge;

    typedef struct packed {
        logic [2:0]          pad;
        logic                hall_valid;
        logic [ANGLE_W-1:0]  rotor_angle;
        logic [SECTOR_W-1:0] sector;
        logic                speed_saturated;
        logic [OMEGA_W-1:0]  omega;
    } t_estimate;

    class hall_estimate_board;
        localparam int RING_DEPTH = WINDOW_DEF;
        localparam logic [95:0] SECTOR_ANGLES = {16'd54613, 16'd43691, 16'd32768,
                                                 16'd21845, 16'd10923, 16'd0};
        bit [PERIOD_W-1:0] period_ring [RING_DEPTH];
        bit [63:0]         window_sum;
        int                write_slot;
        int                fill_count;
        bit [2:0]          held_sector;
        bit [NUM_W-1:0]    speed_numerator;
        t_estimate         expected_estimates [$];
        int                errors;

        function void note_hall_edge(t_hall_edge e);
            t_estimate est;
            bit [63:0] quotient;
            bit [2:0]  code;
            bit [2:0]  sec;
            bit        legal;
            window_sum = window_sum - period_ring[write_slot] + e.period_count;
            period_ring[write_slot] = e.period_count;
            write_slot = (write_slot + 1) % RING_DEPTH;
            if (fill_count < RING_DEPTH) begin
                fill_count++;
            end
            est = '0;
            if (window_sum == 0) begin
                est.omega = '1;
                est.speed_saturated = 1'b1;
            end else begin
                quotient = (64'(speed_numerator) * 64'(fill_count)) / window_sum;
                if (quotient > 64'hFFFF_FFFF) begin
                    est.omega = '1;
                    est.speed_saturated = 1'b1;
                end else begin
                    est.omega = quotient[31:0];
                end
            end
            code = {e.hall_v, e.hall_w, e.hall_u};
            legal = 1'b1;
            sec = 3'd0;
            case (code)
                HALL_S0: sec = 3'd0;
                HALL_S1: sec = 3'd1;
                HALL_S2: sec = 3'd2;
                HALL_S3: sec = 3'd3;
                HALL_S4: sec = 3'd4;
                HALL_S5: sec = 3'd5;
                default: legal = 1'b0;
            endcase
            if (legal) begin
                held_sector = sec;
            end
            est.sector = held_sector;
            est.rotor_angle = SECTOR_ANGLES[held_sector*16 +: 16];
            est.hall_valid = legal;
            expected_estimates.push_back(est);
        endfunction

        function void check_estimate(t_estimate got);
            t_estimate want;
            if (expected_estimates.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word %h", $time, got);
                return;
            end
            want = expected_estimates.pop_front();
            if (got.omega !== want.omega) begin
                errors++;
                $display("%0t: omega expected %h actual %h", $time, want.omega, got.omega);
            end
            if (got.speed_saturated !== want.speed_saturated) begin
                errors++;
                $display("%0t: speed_saturated expected %b actual %b", $time,
                         want.speed_saturated, got.speed_saturated);
            end
            if (got.sector !== want.sector) begin
                errors++;
                $display("%0t: sector expected %0d actual %0d", $time, want.sector, got.sector);
            end
            if (got.rotor_angle !== want.rotor_angle) begin
                errors++;
                $display("%0t: rotor_angle expected %0d actual %0d", $time,
                         want.rotor_angle, got.rotor_angle);
            end
            if (got.hall_valid !== want.hall_valid) begin
                errors++;
                $display("%0t: hall_valid expected %b actual %b", $time,
                         want.hall_valid, got.hall_valid);
            end
        endfunction
    endclass

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                   i_m_tready  = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [NUM_W-1:0]       i_cfg_data  = '0;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_cfg_ready;

    hall_estimate_board board = new;
    int cycle_count = 0;
    int stall_left  = 0;
    bit quiet       = 1'b0;

    hall_speed_angle_estimator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL hall_speed_angle_estimator");
            $finish;
        end
    end

    // result side stalls
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            i_m_tready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                       : $urandom_range(1, 4);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            board.check_estimate(t_estimate'(o_m_tdata));
        end
    end

    task automatic send_hall_edge(input logic [31:0] period, input logic [2:0] code);
        t_hall_edge e;
        int r;
        int gap;
        e = '0;
        e.period_count = period;
        e.hall_u = code[0];
        e.hall_w = code[1];
        e.hall_v = code[2];
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= e;
        do @(posedge i_clk); while (!o_s_tready);
        board.note_hall_edge(e);
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            gap = 0;
        end else if (r < 92) begin
            gap = $urandom_range(1, 4);
        end else begin
            gap = $urandom_range(10, 70);
        end
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.expected_estimates.size() != 0);
    endtask

    task automatic write_numerator(input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.speed_numerator = value;
    endtask

    // rotor sequences with jitter, mixed with illegal codes, noise and stops
    task automatic run_rotation(input int count);
        int i;
        int kind;
        int zero_run;
        int sec_idx;
        int dir;
        logic [31:0] base;
        logic [31:0] period;
        logic [2:0]  code;
        zero_run = 0;
        sec_idx = $urandom_range(0, 5);
        dir = 1;
        base = 32'd1000;
        for (i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                base = 32'($urandom) >> $urandom_range(0, 31);
                quiet = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 29) == 0) begin
                dir = -dir;
            end
            sec_idx = (sec_idx + dir + 6) % 6;
            code = ROTATION[sec_idx*3 +: 3];
            period = base - (base >> 4) + ($urandom % ((base >> 3) + 1));
            kind = $urandom_range(0, 99);
            if (zero_run > 0) begin
                period = '0;
                zero_run--;
            end else if (kind < 70) begin
            end else if (kind < 78) begin
                code = ($urandom_range(0, 1) != 0) ? HALL_ALL_HIGH : HALL_ALL_LOW;
            end else if (kind < 90) begin
                code = 3'($urandom_range(0, 7));
                period = $urandom;
            end else if (kind < 97) begin
                period = $urandom_range(0, 3);
            end else begin
                zero_run = $urandom_range(5, 8);
                period = '0;
            end
            send_hall_edge(period, code);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset numerator, empty window, illegal codes before any legal one
        send_hall_edge(32'd0, HALL_ALL_LOW);
        send_hall_edge(32'd0, HALL_ALL_HIGH);
        send_hall_edge(32'd1000, HALL_S3);
        drain_results();
        write_numerator(32'hFFFF_FFFF);
        send_hall_edge(32'd1, HALL_S0);
        send_hall_edge(32'd1, HALL_S1);
        send_hall_edge(32'd1, HALL_S2);
        send_hall_edge(32'd1, HALL_S3);
        send_hall_edge(32'd1, HALL_S4);
        send_hall_edge(32'd1, HALL_S5);
        send_hall_edge(32'hFFFF_FFFF, HALL_ALL_HIGH);
        send_hall_edge(32'hFFFF_FFFF, HALL_ALL_LOW);
        send_hall_edge(32'hFFFF_FFFF, HALL_S2);
        send_hall_edge(32'h8000_0000, HALL_S1);
        send_hall_edge(32'hFFFF_FFFF, HALL_S0);
        send_hall_edge(32'hFFFF_FFFF, HALL_S5);
        drain_results();
        write_numerator(32'd1);
        // stopped motor: window empties back to zero
        repeat (6) send_hall_edge(32'd0, HALL_S4);
        send_hall_edge(32'd7, HALL_ALL_LOW);

        drain_results();
        write_numerator(32'd268_082_573);
        run_rotation(140);
        drain_results();
        write_numerator(32'd0);
        run_rotation(140);
        drain_results();
        write_numerator(32'hFFFF_FFFF);
        run_rotation(140);
        drain_results();
        write_numerator(32'd1);
        run_rotation(140);
        drain_results();
        write_numerator($urandom);
        run_rotation(140);
        drain_results();
        write_numerator(32'd26_808_257);
        run_rotation(140);

        drain_results();
        quiet = 1'b0;
        repeat (60) @(posedge i_clk);
        if (board.errors == 0 && board.expected_estimates.size() == 0) begin
            $display("PASS hall_speed_angle_estimator");
        end else begin
            $display("FAIL hall_speed_angle_estimator");
        end
        $finish;
    end

endmodule
`default_nettype wire
